### design/rpcr_pkg.sv
`timescale 1ns / 1ps
package rpcr_pkg;

	localparam int NumSteps = 32;
	localparam int NumLanes = 4;
	localparam int IdxW = 8;

	// lanes of the divider chain
	localparam int LaneHitY = 0;
	localparam int LaneHitZ = 1;
	localparam int LaneSlopeY = 2;
	localparam int LaneSlopeZ = 3;

	localparam logic [IdxW-1:0] RegPlaneX = 8'd0;
	localparam logic [IdxW-1:0] RegBackLimitX = 8'd1;
	localparam logic [IdxW-1:0] RegHalfWidth = 8'd2;
	localparam logic [IdxW-1:0] RegMinDirX = 8'd3;

	typedef enum logic [1:0] {
		ACT_CONTINUE = 2'd0,
		ACT_KILL = 2'd1,
		ACT_RECORD = 2'd2
	} action_t;

	typedef struct packed {
		logic [31:0] plane_x;
		logic [31:0] back_limit_x;
		logic [30:0] half_width;
		logic [30:0] min_dir_x;
	} cfg_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] low;
		logic [31:0] dvs;
		logic [31:0] quo;
	} lane_t;

	typedef struct packed {
		action_t action;
		logic [NumLanes-1:0] neg;
		logic [1:0] sat;
		logic [31:0] pre_y;
		logic [31:0] pre_z;
		logic [31:0] weight;
		logic [31:0] origin_y;
	} side_t;

	typedef struct packed {
		logic valid;
		side_t side;
		lane_t [NumLanes-1:0] lane;
	} item_t;

endpackage

### design/rpcr_front.sv
`timescale 1ns / 1ps
module rpcr_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input rpcr_pkg::cfg_t cfg,
	input logic is_photon,
	input logic signed [31:0] pre_x,
	input logic signed [31:0] pre_y,
	input logic signed [31:0] pre_z,
	input logic signed [31:0] post_x,
	input logic signed [31:0] post_y,
	input logic signed [31:0] post_z,
	input logic signed [31:0] dir_x,
	input logic signed [31:0] dir_y,
	input logic signed [31:0] dir_z,
	input logic [31:0] ray_weight,
	input logic signed [31:0] origin_y,
	output rpcr_pkg::item_t item
);

	logic valid_s1, valid_s2;
	logic photon_s1;
	logic signed [31:0] pre_x_s1, pre_y_s1, pre_z_s1, post_x_s1, post_y_s1, post_z_s1;
	logic signed [31:0] dir_x_s1, dir_y_s1, dir_z_s1, origin_s1;
	logic [31:0] weight_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		photon_s1 <= is_photon;
		pre_x_s1 <= pre_x;
		pre_y_s1 <= pre_y;
		pre_z_s1 <= pre_z;
		post_x_s1 <= post_x;
		post_y_s1 <= post_y;
		post_z_s1 <= post_z;
		dir_x_s1 <= dir_x;
		dir_y_s1 <= dir_y;
		dir_z_s1 <= dir_z;
		weight_s1 <= ray_weight;
		origin_s1 <= origin_y;
	end

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic [31:0] mag33(input logic [32:0] v);
		logic [32:0] m;
		m = v[32] ? (~v + 33'd1) : v;
		return m[31:0];
	endfunction

	logic signed [32:0] num_w, den_w, dy_w, dz_w;
	logic [31:0] my_w, mz_w, mpy_w, mpz_w, mdx_w, mdy_w, mdz_w;
	logic [32:0] bl_w, px_w, plx_w, prx_w;
	rpcr_pkg::action_t act_w;

	always_comb begin
		px_w = {post_x_s1[31], post_x_s1};
		prx_w = {pre_x_s1[31], pre_x_s1};
		plx_w = {cfg.plane_x[31], cfg.plane_x};
		bl_w = {cfg.back_limit_x[31], cfg.back_limit_x};
		num_w = $signed(plx_w) - $signed(prx_w);
		den_w = $signed(px_w) - $signed(prx_w);
		dy_w = $signed({post_y_s1[31], post_y_s1}) - $signed({pre_y_s1[31], pre_y_s1});
		dz_w = $signed({post_z_s1[31], post_z_s1}) - $signed({pre_z_s1[31], pre_z_s1});
		my_w = mag33(dy_w);
		mz_w = mag33(dz_w);
		mpy_w = mag32(post_y_s1);
		mpz_w = mag32(post_z_s1);
		mdx_w = mag32(dir_x_s1);
		mdy_w = mag32(dir_y_s1);
		mdz_w = mag32(dir_z_s1);
		priority if (!photon_s1)
			act_w = rpcr_pkg::ACT_CONTINUE;
		else if ($signed(px_w) < $signed(bl_w) && dir_x_s1[31])
			act_w = rpcr_pkg::ACT_KILL;
		else if (mpy_w > {1'b0, cfg.half_width} || mpz_w > {1'b0, cfg.half_width})
			act_w = rpcr_pkg::ACT_KILL;
		else if ($signed(prx_w) >= $signed(plx_w) || $signed(px_w) < $signed(plx_w))
			act_w = rpcr_pkg::ACT_CONTINUE;
		else if (mdx_w < {1'b0, cfg.min_dir_x} || mdx_w == 32'd0)
			act_w = rpcr_pkg::ACT_KILL;
		else
			act_w = rpcr_pkg::ACT_RECORD;
	end

	logic [63:0] prod_y_s2, prod_z_s2;
	logic [31:0] den_s2, mdx_s2, mdy_s2, mdz_s2;
	rpcr_pkg::side_t side_s2;

	always_ff @(posedge clk) begin
		prod_y_s2 <= 64'(num_w[31:0]) * 64'(my_w);
		prod_z_s2 <= 64'(num_w[31:0]) * 64'(mz_w);
		den_s2 <= den_w[31:0];
		mdx_s2 <= mdx_w;
		mdy_s2 <= mdy_w;
		mdz_s2 <= mdz_w;
		side_s2.action <= act_w;
		side_s2.neg[rpcr_pkg::LaneHitY] <= dy_w[32];
		side_s2.neg[rpcr_pkg::LaneHitZ] <= dz_w[32];
		side_s2.neg[rpcr_pkg::LaneSlopeY] <= dir_y_s1[31] ^ dir_x_s1[31];
		side_s2.neg[rpcr_pkg::LaneSlopeZ] <= dir_z_s1[31] ^ dir_x_s1[31];
		side_s2.sat <= 2'b00;
		side_s2.pre_y <= pre_y_s1;
		side_s2.pre_z <= pre_z_s1;
		side_s2.weight <= weight_s1;
		side_s2.origin_y <= origin_s1;
	end

	logic [63:0] dyv, dzv, syv, szv, lim;

	always_comb begin
		// rounding offset of half the divisor folded into each dividend
		dyv = prod_y_s2 + 64'(den_s2[31:1]);
		dzv = prod_z_s2 + 64'(den_s2[31:1]);
		syv = {16'd0, mdy_s2, 16'd0} + 64'(mdx_s2[31:1]);
		szv = {16'd0, mdz_s2, 16'd0} + 64'(mdx_s2[31:1]);
		lim = {1'b0, mdx_s2, 31'd0};
		item.valid = valid_s2;
		item.side = side_s2;
		item.side.sat = {szv >= lim, syv >= lim};
		item.lane[rpcr_pkg::LaneHitY] = '{rem: dyv[63:32], low: dyv[31:0], dvs: den_s2, quo: '0};
		item.lane[rpcr_pkg::LaneHitZ] = '{rem: dzv[63:32], low: dzv[31:0], dvs: den_s2, quo: '0};
		item.lane[rpcr_pkg::LaneSlopeY] = '{rem: syv[63:32], low: syv[31:0], dvs: mdx_s2, quo: '0};
		item.lane[rpcr_pkg::LaneSlopeZ] = '{rem: szv[63:32], low: szv[31:0], dvs: mdx_s2, quo: '0};
	end

endmodule

### design/rpcr_cell.sv
`timescale 1ns / 1ps
module rpcr_cell (
	input logic clk,
	input logic arst_n,
	input rpcr_pkg::item_t din,
	output rpcr_pkg::item_t dout
);

	rpcr_pkg::lane_t [rpcr_pkg::NumLanes-1:0] nxt;
	logic [32:0] trial;
	logic [32:0] diff;
	logic valid_q;
	rpcr_pkg::side_t side_q;
	rpcr_pkg::lane_t [rpcr_pkg::NumLanes-1:0] lane_q;

	// one restoring division step per lane
	always_comb begin
		for (int i = 0; i < rpcr_pkg::NumLanes; i++) begin
			trial = {din.lane[i].rem, din.lane[i].low[31]};
			diff = trial - {1'b0, din.lane[i].dvs};
			nxt[i].dvs = din.lane[i].dvs;
			nxt[i].low = {din.lane[i].low[30:0], 1'b0};
			if (!diff[32]) begin
				nxt[i].rem = diff[31:0];
				nxt[i].quo = {din.lane[i].quo[30:0], 1'b1};
			end else begin
				nxt[i].rem = trial[31:0];
				nxt[i].quo = {din.lane[i].quo[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		side_q <= din.side;
		lane_q <= nxt;
	end

	assign dout = '{valid: valid_q, side: side_q, lane: lane_q};

endmodule

### design/ray_plane_crossing_recorder.sv
`timescale 1ns / 1ps
// Fully pipelined: one photon step per clock, busy stays low, and the result of each item
// appears on the result ports with done high for one cycle, after it passes through two input
// and multiply stages, a 32-cell division chain handling both hit interpolations and both
// slopes and one output stage. The receiver cannot stall, so it must take every result as it
// comes. Configuration writes are always ready and take effect on the next item.
module ray_plane_crossing_recorder (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [rpcr_pkg::IdxW-1:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic is_photon,
	input logic signed [31:0] pre_x,
	input logic signed [31:0] pre_y,
	input logic signed [31:0] pre_z,
	input logic signed [31:0] post_x,
	input logic signed [31:0] post_y,
	input logic signed [31:0] post_z,
	input logic signed [31:0] dir_x,
	input logic signed [31:0] dir_y,
	input logic signed [31:0] dir_z,
	input logic [31:0] ray_weight,
	input logic signed [31:0] origin_y,
	output logic done,
	output logic [1:0] action,
	output logic signed [31:0] hit_y,
	output logic signed [31:0] hit_z,
	output logic signed [31:0] slope_y,
	output logic signed [31:0] slope_z,
	output logic [31:0] weight_out,
	output logic signed [31:0] origin_y_out
);

	rpcr_pkg::cfg_t cfg_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.plane_x <= 32'd0;
			cfg_q.back_limit_x <= 32'hFFFF_0000;
			cfg_q.half_width <= 31'd9830400;
			cfg_q.min_dir_x <= 31'd1074;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rpcr_pkg::RegPlaneX: cfg_q.plane_x <= cfg_data;
				rpcr_pkg::RegBackLimitX: cfg_q.back_limit_x <= cfg_data;
				rpcr_pkg::RegHalfWidth: cfg_q.half_width <= cfg_data[30:0];
				rpcr_pkg::RegMinDirX: cfg_q.min_dir_x <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	rpcr_pkg::item_t chain [0:rpcr_pkg::NumSteps];

	rpcr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(start),
		.cfg(cfg_q),
		.is_photon(is_photon),
		.pre_x(pre_x),
		.pre_y(pre_y),
		.pre_z(pre_z),
		.post_x(post_x),
		.post_y(post_y),
		.post_z(post_z),
		.dir_x(dir_x),
		.dir_y(dir_y),
		.dir_z(dir_z),
		.ray_weight(ray_weight),
		.origin_y(origin_y),
		.item(chain[0])
	);

	for (genvar g = 0; g < rpcr_pkg::NumSteps; g++) begin : g_cell
		rpcr_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.din(chain[g]),
			.dout(chain[g+1])
		);
	end

	rpcr_pkg::item_t last;
	logic rec;
	logic [31:0] qy, qz, sy, sz, sat_y, sat_z;

	always_comb begin
		last = chain[rpcr_pkg::NumSteps];
		rec = (last.side.action == rpcr_pkg::ACT_RECORD);
		qy = last.lane[rpcr_pkg::LaneHitY].quo;
		qz = last.lane[rpcr_pkg::LaneHitZ].quo;
		sy = last.lane[rpcr_pkg::LaneSlopeY].quo;
		sz = last.lane[rpcr_pkg::LaneSlopeZ].quo;
		sat_y = last.side.neg[rpcr_pkg::LaneSlopeY] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		sat_z = last.side.neg[rpcr_pkg::LaneSlopeZ] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		action <= last.side.action;
		if (rec) begin
			hit_y <= last.side.neg[rpcr_pkg::LaneHitY] ? last.side.pre_y - qy
				: last.side.pre_y + qy;
			hit_z <= last.side.neg[rpcr_pkg::LaneHitZ] ? last.side.pre_z - qz
				: last.side.pre_z + qz;
			slope_y <= last.side.sat[0] ? sat_y
				: (last.side.neg[rpcr_pkg::LaneSlopeY] ? (~sy + 32'd1) : sy);
			slope_z <= last.side.sat[1] ? sat_z
				: (last.side.neg[rpcr_pkg::LaneSlopeZ] ? (~sz + 32'd1) : sz);
			weight_out <= last.side.weight;
			origin_y_out <= last.side.origin_y;
		end else begin
			hit_y <= '0;
			hit_z <= '0;
			slope_y <= '0;
			slope_z <= '0;
			weight_out <= '0;
			origin_y_out <= '0;
		end
	end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;

	typedef struct {
		logic is_photon;
		logic signed [31:0] pre_x, pre_y, pre_z;
		logic signed [31:0] post_x, post_y, post_z;
		logic signed [31:0] dir_x, dir_y, dir_z;
		logic [31:0] ray_weight;
		logic signed [31:0] origin_y;
	} step_t;

	typedef struct {
		rpcr_pkg::action_t action;
		logic [31:0] hit_y, hit_z, slope_y, slope_z, weight_out, origin_y_out;
	} crossing_t;

	localparam int Latency = 35;
	localparam int CycleLimit = 400000;

	logic clk, arst_n, busy, cfg_valid, cfg_ready, done;
	logic start = 1'b0;
	logic [rpcr_pkg::IdxW-1:0] cfg_index;
	logic [31:0] cfg_data;
	logic is_photon = 1'b0;
	logic signed [31:0] pre_x = '0, pre_y = '0, pre_z = '0;
	logic signed [31:0] post_x = '0, post_y = '0, post_z = '0;
	logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0, origin_y = '0;
	logic [31:0] ray_weight = '0;
	logic [1:0] action;
	logic signed [31:0] hit_y, hit_z, slope_y, slope_z, origin_y_out;
	logic [31:0] weight_out;

	ray_plane_crossing_recorder u_dut (.*);

	// predictor copy of the registers
	logic signed [63:0] plane_x_r, back_limit_r, half_width_r, min_dir_r;

	step_t pending_steps[$];
	crossing_t expected_crossings[$];
	int mismatches = 0;
	int cycles = 0;
	int gap_left = 0;
	step_t cur_step;
	logic busy_q;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic signed [63:0] lerp_hit(logic signed [63:0] p0,
			logic signed [63:0] p1, logic [63:0] num, logic [63:0] den);
		logic signed [63:0] diff;
		logic [63:0] mag, q;
		diff = p1 - p0;
		mag = diff < 0 ? -diff : diff;
		q = (num * mag + den / 2) / den;
		return diff < 0 ? p0 - q : p0 + q;
	endfunction

	function automatic logic [31:0] slope_of(logic signed [63:0] n, logic signed [63:0] d);
		logic [63:0] mn, md, q;
		mn = n < 0 ? -n : n;
		md = d < 0 ? -d : d;
		q = ((mn << 16) + md / 2) / md;
		if ((n < 0) != (d < 0))
			return q >= 64'h8000_0000 ? 32'h8000_0000 : 32'(-q);
		return q > 64'h7fff_ffff ? 32'h7fff_ffff : q[31:0];
	endfunction

	function automatic crossing_t predict_crossing(step_t s);
		crossing_t r;
		logic signed [63:0] px, ppx, py, pz, dx, ay, az, adx;
		r = '{rpcr_pkg::ACT_CONTINUE, 0, 0, 0, 0, 0, 0};
		px = s.pre_x;
		ppx = s.post_x;
		dx = s.dir_x;
		py = s.post_y;
		pz = s.post_z;
		ay = py < 0 ? -py : py;
		az = pz < 0 ? -pz : pz;
		adx = dx < 0 ? -dx : dx;
		if (!s.is_photon)
			r.action = rpcr_pkg::ACT_CONTINUE;
		else if (ppx < back_limit_r && dx < 0)
			r.action = rpcr_pkg::ACT_KILL;
		else if (ay > half_width_r || az > half_width_r)
			r.action = rpcr_pkg::ACT_KILL;
		else if (px >= plane_x_r || ppx < plane_x_r)
			r.action = rpcr_pkg::ACT_CONTINUE;
		else if (adx < min_dir_r || dx == 0)
			r.action = rpcr_pkg::ACT_KILL;
		else begin
			r.action = rpcr_pkg::ACT_RECORD;
			r.hit_y = 32'(lerp_hit(s.pre_y, py, plane_x_r - px, ppx - px));
			r.hit_z = 32'(lerp_hit(s.pre_z, pz, plane_x_r - px, ppx - px));
			r.slope_y = slope_of(s.dir_y, dx);
			r.slope_z = slope_of(s.dir_z, dx);
			r.weight_out = s.ray_weight;
			r.origin_y_out = s.origin_y;
		end
		return r;
	endfunction

	// records acceptance at the rising edge so the driver knows the item went in
	always @(posedge clk) begin
		busy_q <= busy;
	end

	// driver: presents queued items at the falling edge
	always @(negedge clk) begin
		if (start && !busy_q) begin
			expected_crossings.push_back(predict_crossing(cur_step));
		end
		if (start && busy_q) begin
			// held, keep the item
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			start <= 1'b0;
		end else if (pending_steps.size() > 0 && arst_n) begin
			cur_step = pending_steps.pop_front();
			{is_photon, pre_x, pre_y, pre_z, post_x, post_y, post_z} <= {cur_step.is_photon,
				cur_step.pre_x, cur_step.pre_y, cur_step.pre_z, cur_step.post_x,
				cur_step.post_y, cur_step.post_z};
			{dir_x, dir_y, dir_z, ray_weight, origin_y} <= {cur_step.dir_x, cur_step.dir_y,
				cur_step.dir_z, cur_step.ray_weight, cur_step.origin_y};
			start <= 1'b1;
			gap_left <= pick_gap();
		end else begin
			start <= 1'b0;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// monitor
	always @(posedge clk) begin
		crossing_t e;
		if (arst_n && done) begin
			if (expected_crossings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("result with nothing expected");
			end else begin
				e = expected_crossings.pop_front();
				if (action !== e.action || hit_y !== e.hit_y || hit_z !== e.hit_z ||
						slope_y !== e.slope_y || slope_z !== e.slope_z ||
						weight_out !== e.weight_out || origin_y_out !== e.origin_y_out) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d %h %h %h %h %h %h got %0d %h %h %h %h %h %h",
							e.action, e.hit_y, e.hit_z, e.slope_y, e.slope_z, e.weight_out,
							e.origin_y_out, action, hit_y, hit_z, slope_y, slope_z,
							weight_out, origin_y_out);
				end
			end
		end
	end

	task automatic write_reg(logic [rpcr_pkg::IdxW-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			rpcr_pkg::RegPlaneX: plane_x_r = $signed(val);
			rpcr_pkg::RegBackLimitX: back_limit_r = $signed(val);
			rpcr_pkg::RegHalfWidth: half_width_r = {33'd0, val[30:0]};
			rpcr_pkg::RegMinDirX: min_dir_r = {33'd0, val[30:0]};
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		wait (pending_steps.size() == 0);
		@(posedge clk);
		while (start || expected_crossings.size() > 0) @(posedge clk);
		repeat (Latency + 5) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_dir();
		return $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
	endfunction

	// a crossing step around the current plane, mostly within bounds
	function automatic step_t crossing_step(int span);
		step_t s;
		int dx;
		dx = $urandom_range(1, span);
		s.is_photon = ($urandom_range(0, 19) != 0);
		s.pre_x = 32'(plane_x_r - $urandom_range(1, dx));
		s.post_x = 32'(s.pre_x + dx);
		s.pre_y = $urandom;
		s.pre_z = $urandom;
		s.post_y = $signed($urandom_range(0, 2 * 9830400 + 40)) - 9830420;
		s.post_z = $signed($urandom_range(0, 2 * 9830400 + 40)) - 9830420;
		if ($urandom_range(0, 9) == 0) s.post_y = $urandom;
		s.dir_x = rand_dir();
		if ($urandom_range(0, 7) == 0) s.dir_x = $signed($urandom_range(0, 3000)) - 1500;
		s.dir_y = rand_dir();
		s.dir_z = rand_dir();
		s.ray_weight = $urandom;
		s.origin_y = $urandom;
		return s;
	endfunction

	function automatic step_t noise_step();
		step_t s;
		s.is_photon = 1'($urandom);
		{s.pre_x, s.pre_y, s.pre_z, s.post_x} = {$urandom, $urandom, $urandom, $urandom};
		{s.post_y, s.post_z, s.ray_weight, s.origin_y} = {$urandom, $urandom, $urandom,
			$urandom};
		s.dir_x = $urandom;
		s.dir_y = $urandom;
		s.dir_z = $urandom;
		return s;
	endfunction

	task automatic run_random(int count, int span);
		repeat (count) begin
			if ($urandom_range(0, 9) < 8) pending_steps.push_back(crossing_step(span));
			else pending_steps.push_back(noise_step());
		end
		drain();
	endtask

	initial begin
		step_t s;
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		plane_x_r = 0;
		back_limit_r = -65536;
		half_width_r = 9830400;
		min_dir_r = 1074;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: one of each decision path at reset settings
		s = '{1, -65536, 100, -100, 65536, 300, 200, 32'sh4000_0000, 0, 0, 32'hffff_ffff,
			32'sh8000_0000};
		pending_steps.push_back(s);			// record
		s.is_photon = 0;
		pending_steps.push_back(s);			// non-photon continue
		s = '{1, 0, 0, 0, -131072, 0, 0, -32'sh4000_0000, 0, 0, 1, 1};
		pending_steps.push_back(s);			// backward kill
		s = '{1, -10, 0, 0, 10, 9830401, 0, 32'sh4000_0000, 0, 0, 1, 1};
		pending_steps.push_back(s);			// transverse kill on y
		s.post_y = 0;
		s.post_z = -9830401;
		pending_steps.push_back(s);			// transverse kill on z
		s.post_z = 9830400;
		pending_steps.push_back(s);			// exactly on the bound records
		s = '{1, 0, 0, 0, 10, 0, 0, 32'sh4000_0000, 0, 0, 1, 1};
		pending_steps.push_back(s);			// pre on plane: continue
		s = '{1, -20, 0, 0, -1, 0, 0, 32'sh4000_0000, 0, 0, 1, 1};
		pending_steps.push_back(s);			// short of plane: continue
		s = '{1, -1, 32'sh7fff_ffff, 32'sh8000_0000, 0, 5, -5, 1073, 0, 0, 1, 1};
		pending_steps.push_back(s);			// small dir_x kill
		s.dir_x = -1074;
		s.dir_y = 32'sh4000_0000;
		s.dir_z = -32'sh4000_0000;
		pending_steps.push_back(s);			// saturating slopes
		s.dir_x = 32'sh4000_0000;
		s.dir_y = -32'sh4000_0000;
		s.dir_z = 32'sh4000_0000;
		s.pre_x = 32'sh8000_0000;
		s.post_x = 32'sh7fff_ffff;
		pending_steps.push_back(s);			// longest step
		s = '{1, -1, 0, 0, 1, 1, -1, 3, 1, -1, 0, 0};
		pending_steps.push_back(s);			// small dir_x kill on tie-shaped inputs
		drain();

		write_reg(rpcr_pkg::RegPlaneX, 32'h7fff_ffff);
		write_reg(rpcr_pkg::RegBackLimitX, 32'h8000_0000);
		write_reg(rpcr_pkg::RegHalfWidth, 32'h7fff_ffff);
		write_reg(rpcr_pkg::RegMinDirX, 32'h0);
		s = '{1, 32'sh8000_0000, 1, 2, 32'sh7fff_ffff, 3, 4, 0, 7, 7, 9, 9};
		pending_steps.push_back(s);			// zero direction kill
		s.dir_x = 1;
		pending_steps.push_back(s);
		run_random(150, 1000);

		write_reg(rpcr_pkg::RegPlaneX, 32'h8000_0000);
		write_reg(rpcr_pkg::RegBackLimitX, 32'h7fff_ffff);
		write_reg(rpcr_pkg::RegHalfWidth, 32'h0);
		write_reg(rpcr_pkg::RegMinDirX, 32'h4000_0000);
		run_random(100, 5);

		write_reg(rpcr_pkg::RegPlaneX, $urandom);
		write_reg(rpcr_pkg::RegBackLimitX, $urandom);
		write_reg(rpcr_pkg::RegHalfWidth, 9830400);
		write_reg(rpcr_pkg::RegMinDirX, 1074);
		run_random(350, 32'h7fff_0000);

		if (mismatches == 0 && expected_crossings.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// expectations are queued in the driver at the falling edge after an acceptance
endmodule
